### hdl/wopt_pkg.sv
package wopt_pkg;

   localparam int POSITION_WIDTH_DEF  = 32;
   localparam int TRIG_ITERATIONS_DEF = 16;
   localparam int CORDIC_MAX          = 24;

   localparam int ANGLE_W = 32;   // encoder angle width
   localparam int SUM_W   = 34;   // sum of four encoder angles
   localparam int SCALE_W = 24;
   localparam int FWD_W   = 40;
   localparam int DELTA_W = 41;
   localparam int HEAD_W  = 15;
   localparam int PITCH_W = 14;
   localparam int ANG_W   = 36;   // CORDIC angle, 2^-24 degree units
   localparam int TRIG_W  = 34;   // CORDIC x/y, Q2.30 plus headroom
   localparam int MUL_A_W = 41;
   localparam int MUL_B_W = 34;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd23606;

   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [ANG_W-1:0]  ANG_90  = 36'sd1509949440;
   localparam logic signed [ANG_W-1:0]  ANG_180 = 36'sd3019898880;
   localparam logic signed [ANG_W-1:0]  ANG_360 = 36'sd6039797760;

   typedef struct packed {
      logic start;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   function automatic logic signed [ANG_W-1:0] atan_rom(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 36'sd754974720;
         5'd1:  v = 36'sd445687602;
         5'd2:  v = 36'sd235489088;
         5'd3:  v = 36'sd119537938;
         5'd4:  v = 36'sd60000934;
         5'd5:  v = 36'sd30029717;
         5'd6:  v = 36'sd15018523;
         5'd7:  v = 36'sd7509720;
         5'd8:  v = 36'sd3754917;
         5'd9:  v = 36'sd1877466;
         5'd10: v = 36'sd938734;
         5'd11: v = 36'sd469367;
         5'd12: v = 36'sd234684;
         5'd13: v = 36'sd117342;
         5'd14: v = 36'sd58671;
         5'd15: v = 36'sd29335;
         5'd16: v = 36'sd14668;
         5'd17: v = 36'sd7334;
         5'd18: v = 36'sd3667;
         5'd19: v = 36'sd1833;
         5'd20: v = 36'sd917;
         5'd21: v = 36'sd458;
         5'd22: v = 36'sd229;
         5'd23: v = 36'sd115;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### hdl/wopt_if.sv
interface wopt_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] left_front_angle;
   logic [31:0] left_rear_angle;
   logic [31:0] right_front_angle;
   logic [31:0] right_rear_angle;
   logic [14:0] heading_now;
   logic [13:0] pitch_now;
   logic [31:0] set_x;
   logic [31:0] set_y;

   modport source (output valid, operation, left_front_angle, left_rear_angle,
                   right_front_angle, right_rear_angle, heading_now, pitch_now,
                   set_x, set_y, input ready);
   modport sink (input valid, operation, left_front_angle, left_rear_angle,
                 right_front_angle, right_rear_angle, heading_now, pitch_now,
                 set_x, set_y, output ready);
endinterface

interface wopt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [14:0] heading_out;

   modport source (output valid, pos_x, pos_y, heading_out, input ready);
   modport sink (input valid, pos_x, pos_y, heading_out, output ready);
endinterface

### hdl/wopt_mul.sv
module wopt_mul #(
   parameter int AW = 41,
   parameter int BW = 34
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wopt_pkg::unit_ctl_type    ctl,
   input  logic signed [AW-1:0]      a_in,
   input  logic signed [BW-1:0]      b_in,
   output wopt_pkg::unit_sts_type    sts,
   output logic signed [AW+BW-1:0]   product
);
   import wopt_pkg::*;

   localparam int PW = AW + BW;
   localparam int CW = $clog2(BW + 1);

   logic signed [AW-1:0] a_ff;
   logic [BW-1:0]        b_ff, b_in_nx;
   logic signed [PW-1:0] acc_ff, acc_in, addend;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   // Horner over multiplier bits, MSB first; the sign bit weighs negative
   always_comb begin
      addend = b_ff[BW-1] ? PW'(a_ff) : '0;
      if (cnt_ff == CW'(BW)) addend = -addend;
      acc_in  = acc_ff;
      b_in_nx = b_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         acc_in  = '0;
         b_in_nx = b_in;
         cnt_in  = CW'(BW);
      end else if (cnt_ff != '0) begin
         acc_in  = (acc_ff <<< 1) + addend;
         b_in_nx = b_ff << 1;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      if (ctl.start) a_ff <= a_in;
      acc_ff <= acc_in;
      b_ff   <= b_in_nx;
   end

   assign product  = acc_ff;
   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
endmodule

### hdl/wopt_cordic.sv
module wopt_cordic #(
   parameter int TRIG_ITERATIONS = wopt_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wopt_pkg::unit_ctl_type              ctl,
   input  logic signed [wopt_pkg::ANG_W-1:0]   angle,
   output wopt_pkg::unit_sts_type              sts,
   output logic signed [wopt_pkg::TRIG_W-1:0]  cos_out,
   output logic signed [wopt_pkg::TRIG_W-1:0]  sin_out
);
   import wopt_pkg::*;

   localparam int ITER = (TRIG_ITERATIONS > CORDIC_MAX) ? CORDIC_MAX : TRIG_ITERATIONS;

   logic signed [ANG_W-1:0]  a_ff, a_in, a1, a2;
   logic signed [TRIG_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [4:0]               i_ff, i_in;
   logic                     busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;

   always_comb begin
      // fold into [-180,180), then into [-90,90]
      a1 = angle;
      if (a1 >= ANG_180) a1 = a1 - ANG_360;
      if (a1 < -ANG_180) a1 = a1 + ANG_360;
      a2 = a1;
      neg_in = neg_ff;
      a_in = a_ff; x_in = x_ff; y_in = y_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (ctl.start) begin
         neg_in = 1'b0;
         if (a1 > ANG_90) begin
            a2 = a1 - ANG_180; neg_in = 1'b1;
         end else if (a1 < -ANG_90) begin
            a2 = a1 + ANG_180; neg_in = 1'b1;
         end
         a_in = a2; x_in = CORDIC_GAIN; y_in = '0; i_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!a_ff[ANG_W-1]) begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            a_in = a_ff - atan_rom(i_ff);
         end else begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            a_in = a_ff + atan_rom(i_ff);
         end
         i_in = i_ff + 1'b1;
         if (i_ff == 5'(ITER - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; i_ff <= i_in; neg_ff <= neg_in;
   end

   assign cos_out  = neg_ff ? -x_ff : x_ff;
   assign sin_out  = neg_ff ? -y_ff : y_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
endmodule

### hdl/wheel_odometry_position_tracker.sv
// Sequence: a set item goes through S_FINISH into the result register once the output register is free;
// a first tick runs one forward-travel product only; later ticks add two CORDIC runs and four products.
// Throughput: one item at a time; the bit-serial multiplier (one bit a cycle,
// five products per later tick, one on the first) and the iterative CORDIC set the pace.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears position, prior travel, heading,
// primed flag and sets distance_scale to 23606.
module wheel_odometry_position_tracker #(
   parameter int POSITION_WIDTH  = wopt_pkg::POSITION_WIDTH_DEF,
   parameter int TRIG_ITERATIONS = wopt_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   wopt_req_if.sink                           req_chan,
   wopt_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [wopt_pkg::SCALE_W-1:0]       csr_write_data
);
   import wopt_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL_GO   = 3'd1;
   localparam logic [2:0] S_MUL_WAIT = 3'd2;
   localparam logic [2:0] S_COR_GO   = 3'd3;
   localparam logic [2:0] S_COR_WAIT = 3'd4;
   localparam logic [2:0] S_FINISH   = 3'd5;

   // which product the multiplier is working on
   localparam logic [2:0] P_FWD = 3'd0;
   localparam logic [2:0] P_FX  = 3'd1;
   localparam logic [2:0] P_FY  = 3'd2;
   localparam logic [2:0] P_SX  = 3'd3;
   localparam logic [2:0] P_SY  = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [2:0]                      phase_ff, phase_in;
   logic                            cor_pitch_ff, cor_pitch_in;
   logic [SCALE_W-1:0]              scale_ff;
   logic signed [POSITION_WIDTH-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [FWD_W-1:0]         pfwd_ff, pfwd_in, fwd_ff, fwd_in;
   logic [HEAD_W-1:0]               phead_ff, phead_in, hd_ff;
   logic                            primed_ff, primed_in;
   logic signed [SUM_W-1:0]         sum_ff;
   logic signed [PITCH_W-1:0]       pitch_ff;
   logic signed [DELTA_W-1:0]       delta_ff, delta_in;
   logic signed [TRIG_W-1:0]        hc_ff, hc_in, hs_ff, hs_in, pc_ff, pc_in;
   logic signed [TRIG_W-1:0]        fx_ff, fx_in, fy_ff, fy_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [31:0]                     rsp_x_ff, rsp_y_ff, out_x, out_y;
   logic [HEAD_W-1:0]               rsp_h_ff;
   logic                            accept, load_rsp;
   logic signed [SUM_W-1:0]         sum_nx;

   unit_ctl_type                    mul_ctl, cor_ctl;
   unit_sts_type                    mul_sts, cor_sts;
   logic signed [MUL_A_W-1:0]       mul_a;
   logic signed [MUL_B_W-1:0]       mul_b;
   logic signed [PROD_W-1:0]        prod, prod_q18, prod_q30;
   logic signed [ANG_W-1:0]         cor_angle;
   logic signed [TRIG_W-1:0]        cor_c, cor_s;

   wopt_mul #(.AW(MUL_A_W), .BW(MUL_B_W)) u_mul (
      .clock(clock), .reset(reset), .ctl(mul_ctl), .a_in(mul_a), .b_in(mul_b),
      .sts(mul_sts), .product(prod)
   );

   wopt_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
      .clock(clock), .reset(reset), .ctl(cor_ctl), .angle(cor_angle),
      .sts(cor_sts), .cos_out(cor_c), .sin_out(cor_s)
   );

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign sum_nx = SUM_W'($signed(req_chan.left_front_angle))
                 + SUM_W'($signed(req_chan.left_rear_angle))
                 + SUM_W'($signed(req_chan.right_front_angle))
                 + SUM_W'($signed(req_chan.right_rear_angle));

   // floor shifts of the product
   assign prod_q18 = prod >>> 18;
   assign prod_q30 = prod >>> 30;

   // operand select for the shared multiplier
   always_comb begin
      case (phase_ff)
         P_FWD: begin
            mul_a = MUL_A_W'(sum_ff);
            mul_b = MUL_B_W'({1'b0, scale_ff});
         end
         P_FX: begin
            mul_a = MUL_A_W'(pc_ff);
            mul_b = hs_ff;
         end
         P_FY: begin
            mul_a = MUL_A_W'(pc_ff);
            mul_b = hc_ff;
         end
         P_SX: begin
            mul_a = delta_ff;
            mul_b = fx_ff;
         end
         P_SY: begin
            mul_a = delta_ff;
            mul_b = fy_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // mean heading or pitch, each scaled by 2^18 (the heading sum is shifted by 17)
   always_comb begin
      if (cor_pitch_ff) cor_angle = ANG_W'(pitch_ff) <<< 18;
      else cor_angle = $signed(ANG_W'({1'b0, phead_ff} + {1'b0, hd_ff})) <<< 17;
   end

   assign mul_ctl.start = (state_ff == S_MUL_GO);
   assign cor_ctl.start = (state_ff == S_COR_GO);
   assign load_rsp = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; cor_pitch_in = cor_pitch_ff;
      cx_in = cx_ff; cy_in = cy_ff; pfwd_in = pfwd_ff; fwd_in = fwd_ff;
      phead_in = phead_ff; primed_in = primed_ff; delta_in = delta_ff;
      hc_in = hc_ff; hs_in = hs_ff; pc_in = pc_ff; fx_in = fx_ff; fy_in = fy_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_chan.operation) begin
                  // set item: load coordinates, keep tracking state
                  cx_in = POSITION_WIDTH'($signed(req_chan.set_x));
                  cy_in = POSITION_WIDTH'($signed(req_chan.set_y));
                  state_in = S_FINISH;
               end else begin
                  phase_in = P_FWD;
                  state_in = S_MUL_GO;
               end
            end
         end
         S_MUL_GO: state_in = S_MUL_WAIT;
         S_MUL_WAIT: begin
            if (mul_sts.done) begin
               case (phase_ff)
                  P_FWD: begin
                     fwd_in = prod_q18[FWD_W-1:0];
                     if (primed_ff) begin
                        delta_in = DELTA_W'($signed(prod_q18[FWD_W-1:0])) - DELTA_W'(pfwd_ff);
                        cor_pitch_in = 1'b0;
                        state_in = S_COR_GO;
                     end else begin
                        // first tick primes only
                        pfwd_in = prod_q18[FWD_W-1:0];
                        phead_in = hd_ff;
                        primed_in = 1'b1;
                        state_in = S_FINISH;
                     end
                  end
                  P_FX: begin
                     fx_in = prod_q30[TRIG_W-1:0];
                     phase_in = P_FY;
                     state_in = S_MUL_GO;
                  end
                  P_FY: begin
                     fy_in = prod_q30[TRIG_W-1:0];
                     phase_in = P_SX;
                     state_in = S_MUL_GO;
                  end
                  P_SX: begin
                     cx_in = cx_ff + prod_q30[POSITION_WIDTH-1:0];
                     phase_in = P_SY;
                     state_in = S_MUL_GO;
                  end
                  P_SY: begin
                     cy_in = cy_ff + prod_q30[POSITION_WIDTH-1:0];
                     pfwd_in = fwd_ff;
                     phead_in = hd_ff;
                     state_in = S_FINISH;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_COR_GO: state_in = S_COR_WAIT;
         S_COR_WAIT: begin
            if (cor_sts.done) begin
               if (!cor_pitch_ff) begin
                  hc_in = cor_c;
                  hs_in = cor_s;
                  cor_pitch_in = 1'b1;
                  state_in = S_COR_GO;
               end else begin
                  pc_in = cor_c;
                  phase_in = P_FX;
                  state_in = S_MUL_GO;
               end
            end
         end
         S_FINISH: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // coordinates out, sign-extended or truncated to 32 bits
   generate
      if (POSITION_WIDTH >= 32) begin : g_trunc
         assign out_x = cx_ff[31:0];
         assign out_y = cy_ff[31:0];
      end else begin : g_ext
         assign out_x = 32'(cx_ff);
         assign out_y = 32'(cy_ff);
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= P_FWD;
         cor_pitch_ff <= 1'b0;
         scale_ff     <= SCALE_RESET;
         cx_ff        <= '0;
         cy_ff        <= '0;
         pfwd_ff      <= '0;
         phead_ff     <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cor_pitch_ff <= cor_pitch_in;
         if (csr_write_enable) scale_ff <= csr_write_data;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         pfwd_ff      <= pfwd_in;
         phead_ff     <= phead_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // hold item fields for the duration of the tick
      if (accept) begin
         sum_ff   <= sum_nx;
         hd_ff    <= req_chan.heading_now;
         pitch_ff <= $signed(req_chan.pitch_now);
      end
      fwd_ff <= fwd_in; delta_ff <= delta_in;
      hc_ff <= hc_in; hs_ff <= hs_in; pc_ff <= pc_in; fx_ff <= fx_in; fy_ff <= fy_in;
      if (load_rsp) begin
         rsp_x_ff <= out_x;
         rsp_y_ff <= out_y;
         rsp_h_ff <= phead_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pos_x       = rsp_x_ff;
   assign rsp_chan.pos_y       = rsp_y_ff;
   assign rsp_chan.heading_out = rsp_h_ff;
endmodule
